// ----- hdl/sgcpm_pkg.sv -----
// shared types and constants for the smoothed gain, clip and peak meter block
package sgcpm_pkg;

    // default widths and queue depth, which the module parameters take as their defaults
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int QUEUE_DEPTH        = 2;

    // gain word, unsigned Q4.12 at the default fraction width
    localparam int              GAIN_BITS  = 16;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

    // smoothing factor, about 0.002 in Q0.16
    localparam int              SMOOTH_BITS = 8;
    localparam logic [SMOOTH_BITS-1:0] SMOOTH_Q16 = 8'd131;

    // meter decay factor, about 0.85 in Q0.16
    localparam int              DECAY_BITS = 16;
    localparam logic [DECAY_BITS-1:0] DECAY_Q16 = 16'd55706;

    // shift for the Q0.16 factors, from which the rounding offsets are also formed
    localparam int Q16_SHIFT = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CHAN_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_CHANNELS = 2'd2;

    localparam logic [CHAN_BITS-1:0] CHAN_RESET   = 2'd2;
    localparam logic [CHAN_BITS-1:0] CHAN_STEREO  = 2'd2;

    // what the back end does with one queued sample
    typedef enum logic [1:0] {
        KIND_ONE,   // emit the sample alone
        KIND_HOLD,  // keep the sample as the first of a swapped pair
        KIND_PAIR   // emit the sample, then the held one
    } kind_t;

    typedef struct packed {
        logic  last;
        kind_t kind;
    } item_ctl_t;

    // back end sequencer
    typedef enum logic [2:0] {
        B_IDLE,
        B_STEP,
        B_GAIN,
        B_CLIP,
        B_EMIT_A,
        B_EMIT_B
    } back_state_t;

endpackage

// ----- hdl/sgcpm_front.sv -----
// front end: takes input beats, zeroes silent samples and classifies pairing
module sgcpm_front import sgcpm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          swap_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_silent,
    input  logic                          in_last,
    input  logic                          q_full,
    output logic                          q_push,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    output item_ctl_t                     q_ctl
);

    logic held_reg;
    logic held_next;

    // handshake towards the queue
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_sample = in_silent ? '0 : in_sample;

    // pairing: a held sample is always completed by the next beat
    always_comb begin
        held_next   = held_reg;
        q_ctl.last  = in_last;
        q_ctl.kind  = KIND_ONE;
        if (held_reg) begin
            q_ctl.kind = KIND_PAIR;
            held_next  = 1'b0;
        end else if (swap_mode && !in_last) begin
            q_ctl.kind = KIND_HOLD;
            held_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
        end else if (q_push) begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- hdl/sgcpm_queue.sv -----
// short fifo between the front end and the back end
module sgcpm_queue import sgcpm_pkg::*; #(
    parameter int WIDTH = SAMPLE_BITS_DEF + $bits(item_ctl_t),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    // depth is a power of two; pointers carry one wrap bit
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_BITS:0] wr_ptr_reg;
    logic [PTR_BITS:0] wr_ptr_next;
    logic [PTR_BITS:0] rd_ptr_reg;
    logic [PTR_BITS:0] rd_ptr_next;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[PTR_BITS] != rd_ptr_reg[PTR_BITS]) &&
                      (wr_ptr_reg[PTR_BITS-1:0] == rd_ptr_reg[PTR_BITS-1:0]);
    assign pop_data = mem_reg[rd_ptr_reg[PTR_BITS-1:0]];

    assign wr_ptr_next = wr_ptr_reg + 1'b1;
    assign rd_ptr_next = rd_ptr_reg + 1'b1;

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg[PTR_BITS-1:0]] <= push_data;
        end
    end

endmodule

// ----- hdl/sgcpm_back.sv -----
// back end: gain smoothing, scaling, clipping, peak meter and result output
module sgcpm_back import sgcpm_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [GAIN_BITS-1:0]          target_gain,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  item_ctl_t                     q_ctl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic [SAMPLE_BITS-2:0]        out_meter,
    output logic                          out_run_last,
    output logic                          out_packet_done
);

    localparam int METER_BITS     = SAMPLE_BITS - 1;
    localparam int DIFF_BITS      = GAIN_BITS + 1;
    localparam int STEP_PROD_BITS = DIFF_BITS + SMOOTH_BITS + 1;
    localparam int STEP_BITS      = STEP_PROD_BITS - Q16_SHIFT;
    localparam int DECAY_PROD_BITS = METER_BITS + DECAY_BITS;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;

    localparam logic signed [STEP_PROD_BITS-1:0] STEP_ROUND =
        STEP_PROD_BITS'(64'd1 << (Q16_SHIFT - 1));
    localparam logic [DECAY_PROD_BITS-1:0] DECAY_ROUND =
        DECAY_PROD_BITS'(64'd1 << (Q16_SHIFT - 1));
    localparam logic signed [PROD_BITS-1:0] PROD_ROUND =
        PROD_BITS'(64'd1 << (GAIN_FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] FULL_POS =
        PROD_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PROD_BITS-1:0] FULL_NEG = -FULL_POS;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [SAMPLE_BITS-1:0]     x_reg;
    item_ctl_t                         ctl_reg;
    logic [GAIN_BITS-1:0]              gain_reg;
    logic [GAIN_BITS-1:0]              gain_next;
    logic signed [STEP_PROD_BITS-1:0]  step_prod_reg;
    logic signed [STEP_PROD_BITS-1:0]  step_prod_next;
    logic [DECAY_PROD_BITS-1:0]        decay_prod_reg;
    logic [DECAY_PROD_BITS-1:0]        decay_prod_next;
    logic signed [PROD_BITS-1:0]       prod_reg;
    logic signed [PROD_BITS-1:0]       prod_next;
    logic signed [SAMPLE_BITS-1:0]     v_reg;
    logic signed [SAMPLE_BITS-1:0]     v_next;
    logic signed [SAMPLE_BITS-1:0]     held_reg;
    logic [METER_BITS-1:0]             peak_reg;
    logic [METER_BITS-1:0]             peak_next;
    logic [METER_BITS-1:0]             meter_reg;
    logic [METER_BITS-1:0]             meter_next;

    logic signed [DIFF_BITS-1:0]       diff;
    logic signed [SMOOTH_BITS:0]       smooth_s;
    logic signed [STEP_PROD_BITS-1:0]  step_sum;
    logic signed [STEP_BITS-1:0]       step_val;
    logic signed [GAIN_BITS:0]         gain_s;
    logic signed [PROD_BITS-1:0]       prod_rnd;
    logic signed [PROD_BITS-1:0]       prod_shr;
    logic [METER_BITS-1:0]             mag;
    logic [METER_BITS-1:0]             peak_max;
    logic [DECAY_PROD_BITS-1:0]        decay_sum;
    logic [METER_BITS-1:0]             decayed;

    logic                              out_free;
    logic                              out_load;
    logic signed [SAMPLE_BITS-1:0]     out_sample_next;
    logic                              out_run_last_next;
    logic                              out_packet_done_next;

    logic                              out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]     out_sample_reg;
    logic                              out_run_last_reg;
    logic                              out_packet_done_reg;
    logic [METER_BITS-1:0]             out_meter_reg;

    assign out_free = !out_valid_reg || out_ready;

    // gain step: difference times the smoothing factor; meter times the decay factor
    assign diff           = $signed({1'b0, target_gain}) - $signed({1'b0, gain_reg});
    assign smooth_s       = $signed({1'b0, SMOOTH_Q16});
    assign step_prod_next = diff * smooth_s;
    assign decay_prod_next = DECAY_PROD_BITS'(meter_reg) * DECAY_PROD_BITS'(DECAY_Q16);

    // gain update, then sample times gain
    assign step_sum  = step_prod_reg + STEP_ROUND;
    assign step_val  = step_sum[STEP_PROD_BITS-1:Q16_SHIFT];
    assign gain_next = gain_reg + {{(GAIN_BITS-STEP_BITS){step_val[STEP_BITS-1]}}, step_val};
    assign gain_s    = $signed({1'b0, gain_next});
    assign prod_next = x_reg * gain_s;

    // round, clip to full scale, magnitude
    assign prod_rnd = prod_reg + PROD_ROUND;
    assign prod_shr = prod_rnd >>> GAIN_FRAC_BITS;

    always_comb begin
        if (prod_shr > FULL_POS) begin
            v_next = SAMPLE_BITS'(FULL_POS);
        end else if (prod_shr < FULL_NEG) begin
            v_next = SAMPLE_BITS'(FULL_NEG);
        end else begin
            v_next = prod_shr[SAMPLE_BITS-1:0];
        end
    end

    assign mag      = v_next[SAMPLE_BITS-1] ? METER_BITS'(-v_next) : METER_BITS'(v_next);
    assign peak_max = (mag > peak_reg) ? mag : peak_reg;

    // meter decay and packet end update
    assign decay_sum = decay_prod_reg + DECAY_ROUND;
    assign decayed   = decay_sum[DECAY_PROD_BITS-1:Q16_SHIFT];

    always_comb begin
        peak_next  = peak_max;
        meter_next = meter_reg;
        if (ctl_reg.last) begin
            meter_next = (peak_max > decayed) ? peak_max : decayed;
            peak_next  = '0;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = B_STEP;
                end
            end
            B_STEP: begin
                state_next = B_GAIN;
            end
            B_GAIN: begin
                state_next = B_CLIP;
            end
            B_CLIP: begin
                state_next = (ctl_reg.kind == KIND_HOLD) ? B_IDLE : B_EMIT_A;
            end
            B_EMIT_A: begin
                if (out_free) begin
                    state_next = (ctl_reg.kind == KIND_PAIR) ? B_EMIT_B : B_IDLE;
                end
            end
            B_EMIT_B: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_pop                = 1'b0;
        out_load             = 1'b0;
        out_sample_next      = v_reg;
        out_run_last_next    = 1'b1;
        out_packet_done_next = ctl_reg.last;
        unique case (state_reg)
            B_IDLE: begin
                q_pop = !q_empty;
            end
            B_EMIT_A: begin
                out_load = out_free;
                if (ctl_reg.kind == KIND_PAIR) begin
                    out_run_last_next    = 1'b0;
                    out_packet_done_next = 1'b0;
                end
            end
            B_EMIT_B: begin
                out_load        = out_free;
                out_sample_next = held_reg;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            gain_reg      <= GAIN_RESET;
            peak_reg      <= '0;
            meter_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_GAIN) begin
                gain_reg <= gain_next;
            end
            if (state_reg == B_CLIP) begin
                peak_reg  <= peak_next;
                meter_reg <= meter_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_reg   <= q_sample;
            ctl_reg <= q_ctl;
        end
        if (state_reg == B_STEP) begin
            step_prod_reg  <= step_prod_next;
            decay_prod_reg <= decay_prod_next;
        end
        if (state_reg == B_GAIN) begin
            prod_reg <= prod_next;
        end
        if (state_reg == B_CLIP) begin
            v_reg <= v_next;
            if (ctl_reg.kind == KIND_HOLD) begin
                held_reg <= v_next;
            end
        end
        if (out_load) begin
            out_sample_reg      <= out_sample_next;
            out_run_last_reg    <= out_run_last_next;
            out_packet_done_reg <= out_packet_done_next;
            out_meter_reg       <= meter_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_sample      = out_sample_reg;
    assign out_run_last    = out_run_last_reg;
    assign out_packet_done = out_packet_done_reg;
    assign out_meter       = out_meter_reg;

endmodule

// ----- hdl/smoothed_gain_clip_peak_meter.sv -----
// top level: configuration registers, stream ports, front end, queue and back end
//
// Audio gain ramp with symmetric clip and decaying peak meter. Each input beat is one
// signed Q1.15 sample (tlast ends a packet, tuser marks the sample silent). Before a
// sample is scaled the running gain moves about 0.002 of the way toward target_gain;
// the scaled sample is rounded and saturated to +/- full scale, and at the end of each
// packet the meter takes the larger of the packet peak and 0.85 of its old value. In
// stereo swap mode each pair comes out in reverse order and an odd last sample of a
// packet comes out alone. The front end takes a beat per cycle, while the queue is not
// full, into a two-entry queue; the back end sequencer works one sample at a time:
// queue read, gain step multiply, gain update and sample multiply, clip and meter
// update, output load; a sample closing a swapped pair takes a second load, a held
// sample none. An output load waits while m_tready holds off the previous beat; the
// output register lets a new result load in the cycle the previous one is taken. The
// user must write configuration only while no sample is in flight; the block does not
// enforce it. Running gain starts at unity, follows target_gain only as samples pass.
module smoothed_gain_clip_peak_meter import sgcpm_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int IN_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_BITS  = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration writes
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    // input samples
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // sample_in
    input  logic                      s_tuser,   // silent
    input  logic                      s_tlast,   // packet_last

    // results
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // sample_out, meter_level
    output logic                      m_tuser,   // run_last
    output logic                      m_tlast    // packet_done
);

    localparam int METER_BITS = SAMPLE_BITS - 1;
    localparam int PAD_BITS   = OUT_DATA_BITS - SAMPLE_BITS - METER_BITS;
    localparam int Q_WIDTH    = SAMPLE_BITS + $bits(item_ctl_t);

    logic [GAIN_BITS-1:0]          target_gain_reg;
    logic [CHAN_BITS-1:0]          channel_count_reg;
    logic                          swap_channels_reg;
    logic                          swap_mode;

    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    logic signed [SAMPLE_BITS-1:0] q_in_sample;
    item_ctl_t                     q_in_ctl;
    logic [Q_WIDTH-1:0]            q_out_data;
    logic signed [SAMPLE_BITS-1:0] q_out_sample;
    item_ctl_t                     q_out_ctl;

    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [METER_BITS-1:0]         out_meter;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_gain_reg   <= GAIN_RESET;
            channel_count_reg <= CHAN_RESET;
            swap_channels_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TARGET_GAIN:   target_gain_reg   <= cfg_data[GAIN_BITS-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_BITS-1:0];
                REG_SWAP_CHANNELS: swap_channels_reg <= cfg_data[0];
                default:           swap_channels_reg <= swap_channels_reg;
            endcase
        end
    end

    assign swap_mode = (channel_count_reg == CHAN_STEREO) && swap_channels_reg;

    // front end
    sgcpm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .swap_mode (swap_mode),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_silent (s_tuser),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_sample  (q_in_sample),
        .q_ctl     (q_in_ctl)
    );

    // queue between the two halves
    sgcpm_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({q_in_ctl, q_in_sample}),
        .pop       (q_pop),
        .pop_data  (q_out_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign q_out_sample = q_out_data[SAMPLE_BITS-1:0];
    assign q_out_ctl    = q_out_data[Q_WIDTH-1:SAMPLE_BITS];

    // back end
    sgcpm_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .target_gain     (target_gain_reg),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_sample        (q_out_sample),
        .q_ctl           (q_out_ctl),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_sample      (out_sample),
        .out_meter       (out_meter),
        .out_run_last    (m_tuser),
        .out_packet_done (m_tlast)
    );

    // result beat packing
    assign m_tdata = {{PAD_BITS{1'b0}}, out_meter, out_sample};

endmodule

// ----- verif/smoothed_gain_clip_peak_meter_tb.sv -----
// testbench for the smoothed gain, clip and peak meter block: directed and random packets
module smoothed_gain_clip_peak_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgcpm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 730;
    localparam int MAX_PRINTS    = 40;

    localparam longint FULL_SCALE = 32767;
    localparam longint Q16_HALF   = 64'sd1 << (Q16_SHIFT - 1);
    localparam longint GAIN_HALF  = 64'sd1 << (GAIN_FRAC_BITS_DEF - 1);

    // register index past the end of the list, writes are dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // channel count codes; only stereo enables swapping
    localparam logic [CHAN_BITS-1:0] CHAN_ZERO  = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_MONO  = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_THREE = 2'd3;

    localparam logic [GAIN_BITS-1:0] GAIN_ZERO = 16'h0000;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX  = 16'hFFFF;

    localparam logic [15:0] POS_FULL  = 16'h7FFF;
    localparam logic [15:0] NEG_FULL  = 16'h8000;
    localparam logic [15:0] MINUS_ONE = 16'hFFFF;
    localparam logic [15:0] PLUS_ONE  = 16'h0001;
    localparam logic [15:0] HALF_POS  = 16'h4000;

    // one result beat as the block should produce it
    typedef struct {
        logic [15:0] sample;
        logic        run_last;
        logic        packet_done;
        logic [14:0] meter;
    } out_beat_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata   = '0;   // sample_in
    logic                      s_tuser   = 1'b0; // silent
    logic                      s_tlast   = 1'b0; // packet_last
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;          // sample_out, meter_level
    logic                      m_tuser;          // run_last
    logic                      m_tlast;          // packet_done

    // predictor state and its copy of the registers
    logic [GAIN_BITS-1:0] gain_target  = GAIN_RESET;
    logic [CHAN_BITS-1:0] chan_sel     = CHAN_RESET;
    logic                 swap_on      = 1'b0;
    logic [GAIN_BITS-1:0] ramp_gain    = GAIN_RESET;
    logic [15:0]          parked_sample = '0;
    logic                 parked_valid = 1'b0;
    logic [14:0]          pkt_peak     = '0;
    logic [14:0]          meter_now    = '0;

    out_beat_t pending_out_beats[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit tx_gap_on      = 1'b0;
    bit rx_stall_on    = 1'b0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_left     = 0;

    smoothed_gain_clip_peak_meter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample values leaning toward full scale and small magnitudes
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return POS_FULL;
            1: return NEG_FULL;
            2: return 16'($urandom_range(0, 63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want_val);
    endtask

    // append one expected beat at the tail of the list
    task automatic expect_beat(input out_beat_t beat);
        pending_out_beats = {pending_out_beats, beat};
    endtask

    // gain ramp, clip, peak meter and swap pairing for one accepted sample
    task automatic predict_beats(input logic [15:0] raw, input logic silent_flag,
                                 input logic last_flag);
        longint x, diff, step, v, mag, decayed;
        out_beat_t beat;
        x = silent_flag ? 64'sd0 : longint'($signed(raw));

        // gain moves first, then scales this sample
        diff = longint'(gain_target) - longint'(ramp_gain);
        step = (diff * longint'(SMOOTH_Q16) + Q16_HALF) >>> Q16_SHIFT;
        ramp_gain = 16'(longint'(ramp_gain) + step);
        v = (x * longint'(ramp_gain) + GAIN_HALF) >>> GAIN_FRAC_BITS_DEF;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        if (v < -FULL_SCALE)
            v = -FULL_SCALE;

        // packet peak and meter decay at packet end
        mag = (v < 0) ? -v : v;
        if (mag > longint'(pkt_peak))
            pkt_peak = 15'(mag);
        if (last_flag) begin
            decayed = (longint'(meter_now) * longint'(DECAY_Q16) + Q16_HALF) >> Q16_SHIFT;
            meter_now = (longint'(pkt_peak) > decayed) ? pkt_peak : 15'(decayed);
            pkt_peak = '0;
        end

        // a parked sample always completes its pair, whatever the mode now is
        if (parked_valid) begin
            beat = '{v[15:0], 1'b0, 1'b0, meter_now};
            expect_beat(beat);
            beat = '{parked_sample, 1'b1, last_flag, meter_now};
            expect_beat(beat);
            parked_valid = 1'b0;
            parked_sample = '0;
        end else if (chan_sel == CHAN_STEREO && swap_on && !last_flag) begin
            parked_sample = v[15:0];
            parked_valid = 1'b1;
        end else begin
            beat = '{v[15:0], 1'b1, last_flag, meter_now};
            expect_beat(beat);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out_beats.size() == 0) begin
                report_mismatch("unexpected beat, sample", $signed(m_tdata[15:0]), 0);
            end else begin
                want = pending_out_beats.pop_front();
                if (m_tdata[15:0] !== want.sample)
                    report_mismatch("sample_out", $signed(m_tdata[15:0]), $signed(want.sample));
                if (m_tdata[30:16] !== want.meter)
                    report_mismatch("meter_level", m_tdata[30:16], want.meter);
                if (m_tdata[31] !== 1'b0)
                    report_mismatch("tdata pad bit", m_tdata[31], 0);
                if (m_tuser !== want.run_last)
                    report_mismatch("run_last", m_tuser, want.run_last);
                if (m_tlast !== want.packet_done)
                    report_mismatch("packet_done", m_tlast, want.packet_done);
            end
        end
    end

    // receiver: random stalls plus a long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // offer one sample beat and wait for it to be taken
    task automatic send_sample(input logic [15:0] sample, input logic silent_flag,
                               input logic last_flag);
        int gap;
        gap = tx_gap_on ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tuser <= silent_flag;
        s_tlast <= last_flag;
        do @(posedge aclk); while (!s_tready);
        predict_beats(sample, silent_flag, last_flag);
    endtask

    // stop offering, drain every expected beat, then let a held sample settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_out_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        case (idx)
            REG_TARGET_GAIN:   gain_target = data;
            REG_CHANNEL_COUNT: chan_sel = data[CHAN_BITS-1:0];
            REG_SWAP_CHANNELS: swap_on = data[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    // unity gain out of reset: full scale both ways, sign edges, silence, packet end
    task automatic test_unity_extremes();
        send_sample(POS_FULL, 1'b0, 1'b0);
        send_sample(NEG_FULL, 1'b0, 1'b0);
        send_sample(MINUS_ONE, 1'b0, 1'b0);
        send_sample(PLUS_ONE, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(POS_FULL, 1'b1, 1'b0);
        send_sample(HALF_POS, 1'b0, 1'b1);
    endtask

    // target gain at both ends; ramp starts from unity and clips on the way up
    task automatic test_gain_extremes();
        write_reg(REG_TARGET_GAIN, GAIN_MAX);
        send_sample(POS_FULL, 1'b0, 1'b0);
        send_sample(NEG_FULL, 1'b0, 1'b1);
        write_reg(REG_TARGET_GAIN, GAIN_ZERO);
        send_sample(HALF_POS, 1'b0, 1'b0);
        send_sample(NEG_FULL, 1'b0, 1'b1);
    endtask

    // swapped pairs, odd final sample, mode change while a sample is parked
    task automatic test_swap_pairs();
        write_reg(REG_SWAP_CHANNELS, 16'd1);
        send_sample(16'h1234, 1'b0, 1'b0);
        send_sample(16'hEDCB, 1'b0, 1'b0);
        send_sample(16'h0100, 1'b0, 1'b0);
        send_sample(16'hFF00, 1'b0, 1'b1);
        send_sample(16'h2222, 1'b0, 1'b1);
        send_sample(16'h0FFF, 1'b0, 1'b0);
        write_reg(REG_SWAP_CHANNELS, 16'd0);
        send_sample(16'hF001, 1'b0, 1'b0);
    endtask

    // swap enabled but not stereo, and a write to the unused index
    task automatic test_channel_modes();
        write_reg(REG_SWAP_CHANNELS, 16'd1);
        write_reg(REG_CHANNEL_COUNT, 16'(CHAN_ZERO));
        send_sample(16'h7001, 1'b0, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 16'(CHAN_MONO));
        send_sample(16'h8FFF, 1'b0, 1'b0);
        write_reg(REG_CHANNEL_COUNT, 16'(CHAN_THREE));
        send_sample(16'h5555, 1'b0, 1'b0);
        write_reg(REG_UNUSED, 16'($urandom));
        send_sample(16'hAAAA, 1'b1, 1'b1);
        write_reg(REG_CHANNEL_COUNT, 16'(CHAN_STEREO));
        write_reg(REG_SWAP_CHANNELS, 16'd0);
    endtask

    // receiver holds off for a long stretch while samples keep coming
    task automatic test_output_stall();
        tx_gap_on = 1'b0;
        rx_stall_on = 1'b0;
        write_reg(REG_SWAP_CHANNELS, 16'd1);
        hold_requests++;
        for (int k = 0; k < 16; k++)
            send_sample(rand_sample(), 1'b0, k == 15);
        write_reg(REG_SWAP_CHANNELS, 16'd0);
    endtask

    // random packets under a series of register settings
    task automatic test_random_packets();
        int sent, phase_items, phase_len, plen;
        logic silent_pkt;
        logic [GAIN_BITS-1:0] gain;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            case (phase % 4)
                0: gain = GAIN_MAX;
                1: gain = GAIN_ZERO;
                2: gain = GAIN_RESET;
                default: gain = 16'($urandom);
            endcase
            write_reg(REG_TARGET_GAIN, gain);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_CHANNEL_COUNT, 16'($urandom_range(0, 3)));
            else
                write_reg(REG_CHANNEL_COUNT, 16'(CHAN_STEREO));
            write_reg(REG_SWAP_CHANNELS, 16'($urandom_range(0, 1)));
            tx_gap_on = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);

            phase_len = $urandom_range(60, 140);
            phase_items = 0;
            while (phase_items < phase_len) begin
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 6);
                silent_pkt = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < plen; k++)
                    send_sample(rand_sample(), silent_pkt | ($urandom_range(0, 31) == 0),
                                k == plen - 1);
                phase_items += plen;
                sent += plen;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unity_extremes();
        test_gain_extremes();
        test_swap_pairs();
        test_channel_modes();
        test_output_stall();
        test_random_packets();

        wait_quiet();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
